FILE: src/qrii_pkg.sv
// Package for the quadratic root solver: payload structs, kind codes, widths.
// No dependencies.
package qrii_pkg;

  localparam int unsigned CoefW = 16;
  localparam int unsigned OutW  = 48;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_TWO     = 2'd1,
    KIND_DOUBLE  = 2'd2,
    KIND_COMPLEX = 2'd3
  } root_kind_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_quad;
    logic signed [CoefW-1:0] coef_lin;
    logic signed [CoefW-1:0] coef_const;
    logic signed [CoefW-1:0] bound_one;
    logic signed [CoefW-1:0] bound_two;
  } qrii_req_t;

  typedef struct packed {
    root_kind_e            root_kind;
    logic signed [OutW-1:0] first_value;
    logic signed [OutW-1:0] second_value;
    logic                   first_inside;
    logic                   second_inside;
  } qrii_res_t;

endpackage

FILE: src/qrii_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
// Depends on nothing but its parameters; carries a side payload alongside.
module qrii_sqrt #(
  parameter int unsigned RadW  = 96,
  parameter int unsigned SideW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [RadW-1:0]      rad_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [RadW/2-1:0]    root_o,
  output logic [SideW-1:0]     side_o
);

  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned RemW  = RootW + 2;

  logic [RootW:1]           vld_q;
  logic [RadW-1:0]          rad_q  [1:RootW];
  logic [RemW-1:0]          rem_q  [1:RootW];
  logic [RootW-1:0]         root_q [1:RootW];
  logic [SideW-1:0]         side_q [1:RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic             vld_in;
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SideW-1:0] side_in;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  rem_sh;
    if (k == 0) begin : g_head
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[k];
      assign rad_in  = rad_q[k];
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
      assign side_in = side_q[k];
    end
    always_comb begin
      rem_sh = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
      trial  = {root_in, 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[k+1]  <= rad_in << 2;
      side_q[k+1] <= side_in;
      if (rem_sh >= trial) begin
        rem_q[k+1]  <= rem_sh - trial;
        root_q[k+1] <= {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_q[k+1]  <= rem_sh;
        root_q[k+1] <= {root_in[RootW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = root_q[RootW];
  assign side_o  = side_q[RootW];

endmodule

FILE: src/qrii_div.sv
// Pipelined signed divider, quotient truncated toward zero, one bit per stage.
// Depends on nothing but its parameters; carries a side payload alongside.
module qrii_div #(
  parameter int unsigned NumW  = 64,
  parameter int unsigned DenW  = 34,
  parameter int unsigned SideW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [NumW-1:0]  num_i,
  input  logic signed [DenW-1:0]  den_i,
  input  logic [SideW-1:0]        side_i,
  output logic                    valid_o,
  output logic signed [NumW-1:0]  quo_o,
  output logic [SideW-1:0]        side_o
);

  logic [NumW:1]      vld_q;
  logic [NumW-1:0]    num_q  [1:NumW];
  logic [NumW-1:0]    rem_q  [1:NumW];
  logic [DenW-1:0]    den_q  [1:NumW];
  logic               neg_q  [1:NumW];
  logic [SideW-1:0]   side_q [1:NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic             vld_in;
    logic [NumW-1:0]  num_in;
    logic [NumW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic             neg_in;
    logic [SideW-1:0] side_in;
    logic [NumW:0]    rem_sh;
    logic [NumW:0]    den_x;
    if (k == 0) begin : g_head
      // work on magnitudes, restore the sign at the end
      assign vld_in  = valid_i;
      assign num_in  = num_i[NumW-1] ? NumW'(-num_i) : num_i;
      assign rem_in  = '0;
      assign den_in  = den_i[DenW-1] ? DenW'(-den_i) : den_i;
      assign neg_in  = num_i[NumW-1] ^ den_i[DenW-1];
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[k];
      assign num_in  = num_q[k];
      assign rem_in  = rem_q[k];
      assign den_in  = den_q[k];
      assign neg_in  = neg_q[k];
      assign side_in = side_q[k];
    end
    always_comb begin
      rem_sh = {rem_in, num_in[NumW-1]};
      den_x  = (NumW+1)'(den_in);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      den_q[k+1]  <= den_in;
      neg_q[k+1]  <= neg_in;
      side_q[k+1] <= side_in;
      if (rem_sh >= den_x) begin
        rem_q[k+1] <= NumW'(rem_sh - den_x);
        num_q[k+1] <= {num_in[NumW-2:0], 1'b1};
      end else begin
        rem_q[k+1] <= NumW'(rem_sh);
        num_q[k+1] <= {num_in[NumW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o   = neg_q[NumW] ? -$signed(num_q[NumW]) : $signed(num_q[NumW]);
  assign side_o  = side_q[NumW];

endmodule

FILE: src/quadratic_roots_in_interval.sv
// Quadratic root solver with closed-interval test. One request per cycle,
// results one per request in request order. The pipeline is 3 front stages,
// one stage per root bit of the square root (CoefW+FRAC_BITS+2 stages), one
// stage per numerator bit of the two dividers (CoefW+FRAC_BITS+4 stages), and
// one output stage before the result strobe; the receiver cannot stall and
// busy is always low.
// Depends on qrii_pkg, qrii_sqrt, qrii_div.
module quadratic_roots_in_interval
  import qrii_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  qrii_req_t  req_i,
  output logic       res_valid_o,
  output qrii_res_t  res_o
);

  localparam int unsigned DeltaW = 2 * CoefW + 3;
  localparam int unsigned RadW   = 2 * ((DeltaW + 2 * FRAC_BITS + 1) / 2);
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned NumW   = CoefW + FRAC_BITS + 3 > RootW + 2 ?
                                   CoefW + FRAC_BITS + 3 : RootW + 2;
  localparam int unsigned DenW   = CoefW + 1;
  localparam int unsigned BndW   = CoefW + FRAC_BITS + 1;
  localparam int unsigned SideW  = 2 * BndW + 2 + NumW + DenW;
  localparam int unsigned DsW    = 2 * BndW + 2;
  localparam int unsigned CmpW   = NumW > OutW ? NumW : OutW;
  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // stage 1: order bounds, form products
  logic                      v1_q;
  logic signed [CoefW-1:0]   a1_q, b1_q, lo1_q, hi1_q;
  logic signed [2*CoefW-1:0] bb1_q, ac1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= accept;
  end
  always_ff @(posedge clk_i) begin
    a1_q  <= req_i.coef_quad;
    b1_q  <= req_i.coef_lin;
    bb1_q <= req_i.coef_lin * req_i.coef_lin;
    ac1_q <= req_i.coef_quad * req_i.coef_const;
    if (req_i.bound_one > req_i.bound_two) begin
      lo1_q <= req_i.bound_two; hi1_q <= req_i.bound_one;
    end else begin
      lo1_q <= req_i.bound_one; hi1_q <= req_i.bound_two;
    end
  end

  // stage 2: discriminant
  logic                     v2_q;
  logic signed [CoefW-1:0]  a2_q, b2_q, lo2_q, hi2_q;
  logic signed [DeltaW-1:0] dl2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    a2_q  <= a1_q; b2_q <= b1_q; lo2_q <= lo1_q; hi2_q <= hi1_q;
    dl2_q <= DeltaW'(bb1_q) - (DeltaW'(ac1_q) <<< 2);
  end

  // stage 3: kind, magnitude, scaled operands
  logic                    v3_q;
  root_kind_e              k3_q;
  logic [RadW-1:0]         rad3_q;
  logic signed [NumW-1:0]  nb3_q;
  logic signed [DenW-1:0]  den3_q;
  logic signed [BndW-1:0]  lo3_q, hi3_q;
  root_kind_e              k3_d;
  logic [DeltaW-1:0]       mag3;
  always_comb begin
    if (a2_q == '0) k3_d = KIND_NONE;
    else if (dl2_q < 0) k3_d = KIND_COMPLEX;
    else if (dl2_q == '0) k3_d = KIND_DOUBLE;
    else k3_d = KIND_TWO;
    mag3 = dl2_q[DeltaW-1] ? DeltaW'(-dl2_q) : DeltaW'(dl2_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    k3_q   <= k3_d;
    rad3_q <= RadW'(mag3) << (2 * FRAC_BITS);
    nb3_q  <= -(NumW'(b2_q) <<< FRAC_BITS);
    den3_q <= DenW'(a2_q) <<< 1;
    lo3_q  <= BndW'(lo2_q) <<< FRAC_BITS;
    hi3_q  <= BndW'(hi2_q) <<< FRAC_BITS;
  end

  // square root, side data rides along
  logic             vs;
  logic [RootW-1:0] root_s;
  logic [SideW-1:0] side_s;
  qrii_sqrt #(.RadW(RadW), .SideW(SideW)) u_sqrt (
    .clk_i, .rst_ni, .valid_i(v3_q), .rad_i(rad3_q),
    .side_i({k3_q, lo3_q, hi3_q, nb3_q, den3_q}),
    .valid_o(vs), .root_o(root_s), .side_o(side_s));

  root_kind_e             ks;
  logic signed [BndW-1:0] los, his;
  logic signed [NumW-1:0] nbs, sv, n1, n2;
  logic signed [DenW-1:0] dens;
  always_comb begin
    {ks, los, his, nbs, dens} = side_s;
    sv = NumW'(root_s);
    unique case (ks)
      KIND_TWO: begin
        n1 = nbs + sv; n2 = nbs - sv;
      end
      KIND_COMPLEX: begin
        n1 = nbs; n2 = sv;
      end
      default: begin
        n1 = nbs; n2 = '0;
      end
    endcase
  end

  logic                   vd1, vd2;
  logic signed [NumW-1:0] q1, q2;
  logic [DsW-1:0]         sd1, sd2;
  qrii_div #(.NumW(NumW), .DenW(DenW), .SideW(DsW)) u_div_first (
    .clk_i, .rst_ni, .valid_i(vs), .num_i(n1), .den_i(dens),
    .side_i({ks, los, his}), .valid_o(vd1), .quo_o(q1), .side_o(sd1));
  qrii_div #(.NumW(NumW), .DenW(DenW), .SideW(DsW)) u_div_second (
    .clk_i, .rst_ni, .valid_i(vs), .num_i(n2), .den_i(dens),
    .side_i({ks, los, his}), .valid_o(vd2), .quo_o(q2), .side_o(sd2));

  // compare at the wider of the two widths so neither limit wraps
  function automatic logic signed [OutW-1:0] sat(input logic signed [NumW-1:0] v);
    logic signed [CmpW-1:0] w;
    w = CmpW'(v);
    if (w > CmpW'(OutMax)) return OutMax;
    if (w < CmpW'(OutMin)) return OutMin;
    return OutW'(w);
  endfunction

  root_kind_e             kf;
  logic signed [BndW-1:0] lof, hif;
  logic signed [NumW-1:0] lox, hix;
  qrii_res_t              res_d;
  logic                   vo_q;
  qrii_res_t              res_q;
  always_comb begin
    {kf, lof, hif} = sd1;
    lox = NumW'(lof); hix = NumW'(hif);
    res_d = '0;
    res_d.root_kind = kf;
    unique case (kf)
      KIND_TWO: begin
        res_d.first_value   = sat(q1);
        res_d.second_value  = sat(q2);
        res_d.first_inside  = q1 >= lox && q1 <= hix;
        res_d.second_inside = q2 >= lox && q2 <= hix;
      end
      KIND_DOUBLE: begin
        res_d.first_value  = sat(q1);
        res_d.first_inside = q1 >= lox && q1 <= hix;
      end
      KIND_COMPLEX: begin
        res_d.first_value  = sat(q1);
        res_d.second_value = sat(q2);
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else vo_q <= vd1;
  end
  always_ff @(posedge clk_i) res_q <= res_d;

  assign res_valid_o = vo_q;
  assign res_o       = res_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd1 == vd2) else $error("dividers out of step");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.root_kind == KIND_NONE |->
      res_o.first_value == '0 && !res_o.first_inside)
    else $error("non-quadratic result not cleared");
  a_complex_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.root_kind == KIND_COMPLEX |->
      !res_o.first_inside && !res_o.second_inside)
    else $error("complex pair flagged inside");
  a_double_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.root_kind == KIND_DOUBLE |-> res_o.second_value == '0)
    else $error("double root second value set");

endmodule
